@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define RQD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every rising clock edge, also during reset
`define RQD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/rqd_pkg.sv @@
package rqd_pkg;

	localparam int MAX_SOURCES_DEF = 8;
	localparam int COUNT_BITS_DEF  = 8;

	localparam int SRC_W      = 4;
	localparam int NUM_W      = 4;
	localparam int EXP_W      = 64;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [1:0] {
		MODE_ANY   = 2'd0,
		MODE_EACH  = 2'd1,
		MODE_COUNT = 2'd2
	} mode_t;

	localparam logic [CFG_ADDR_W-1:0] REG_MODE     = 4'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_NUM_SRC  = 4'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_EXPECTED = 4'd2;

	localparam logic [NUM_W-1:0] NUM_SRC_RST  = 4'd8;
	localparam logic [EXP_W-1:0] EXPECTED_RST = 64'h0101_0101_0101_0101;

endpackage

@@ src/rqd_req_if.sv @@
interface rqd_req_if;
	logic                     valid;
	logic                     ready;
	logic [rqd_pkg::SRC_W-1:0] source;

	modport src (output valid, output source, input ready);
	modport sink (input valid, input source, output ready);
endinterface

@@ src/rqd_rsp_if.sv @@
interface rqd_rsp_if;
	logic valid;
	logic ready;
	logic fired;
	logic bad_source;

	modport src (output valid, output fired, output bad_source, input ready);
	modport sink (input valid, input fired, input bad_source, output ready);
endinterface

@@ src/rqd_cfg_if.sv @@
interface rqd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rqd_pkg::CFG_ADDR_W-1:0] addr;
	logic [rqd_pkg::CFG_DATA_W-1:0] data;

	modport src (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

@@ src/reply_quorum_detector.sv @@
// Reply quorum detector. Each beat on req carries the number of the source
// that sent a reply; each accepted beat yields exactly one beat on rsp with
// fired (the quorum was met and the condition rearmed) and bad_source (the
// source is not below the number of sources in use; the reply is ignored).
// Mode 0 fires on every good reply, mode 1 fires once every source in use has
// replied, mode 2 fires once every source in use has a remaining count of zero,
// then reloads the counts from expected_counts. A write to any of the three
// registers reloads the counts; a write to any other index does nothing.
// The user must write registers through cfg only while no reply is in flight;
// the block does not enforce it. Throughput is one reply per cycle while rsp
// is ready; the result appears in the cycle after the beat is accepted, from
// the single output register; req stays ready while it is empty or being taken.
`include "assert_macros.svh"

module reply_quorum_detector #(
	parameter int MAX_SOURCES = rqd_pkg::MAX_SOURCES_DEF,
	parameter int COUNT_BITS  = rqd_pkg::COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rqd_req_if.sink   req,
	rqd_rsp_if.src    rsp,
	rqd_cfg_if.sink   cfg
);

	localparam logic [rqd_pkg::NUM_W-1:0] MAX_N = rqd_pkg::NUM_W'(MAX_SOURCES);

	typedef logic [MAX_SOURCES-1:0][COUNT_BITS-1:0] cnt_arr_t;

	rqd_pkg::mode_t                 mode_q;
	logic [rqd_pkg::NUM_W-1:0]      num_q;
	logic [rqd_pkg::EXP_W-1:0]      exp_q;
	logic [MAX_SOURCES-1:0]         seen_q;
	cnt_arr_t                       cnt_q;
	logic                           rsp_valid_q;
	logic                           fired_q;
	logic                           bad_q;

	logic                           req_acc;
	logic                           cfg_acc;
	logic [rqd_pkg::NUM_W-1:0]      n_c;
	logic [MAX_SOURCES-1:0]         in_use_c;
	logic [MAX_SOURCES-1:0]         hit_c;
	logic [MAX_SOURCES-1:0]         seen_next_c;
	logic [MAX_SOURCES-1:0]         zero_ok_c;
	cnt_arr_t                       cnt_dec_c;
	cnt_arr_t                       reload_c;
	logic [rqd_pkg::EXP_W-1:0]      exp_next_c;
	logic                           bad_c;
	logic                           each_done_c;
	logic                           count_done_c;
	logic                           fire_c;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;
	assign req_acc   = req.valid && req.ready;
	assign cfg_acc   = cfg.valid;

	assign rsp.valid      = rsp_valid_q;
	assign rsp.fired      = fired_q;
	assign rsp.bad_source = bad_q;

	assign n_c   = (num_q > MAX_N) ? MAX_N : num_q;
	assign bad_c = req.source >= n_c;

	assign exp_next_c = (cfg_acc && cfg.addr == rqd_pkg::REG_EXPECTED) ? cfg.data : exp_q;

	always_comb begin
		for (int i = 0; i < MAX_SOURCES; i++) begin
			in_use_c[i]    = rqd_pkg::NUM_W'(i) < n_c;
			hit_c[i]       = req.source == rqd_pkg::SRC_W'(i);
			seen_next_c[i] = seen_q[i] || hit_c[i];
			cnt_dec_c[i]   = (hit_c[i] && cnt_q[i] != '0) ? cnt_q[i] - 1'b1 : cnt_q[i];
			zero_ok_c[i]   = !in_use_c[i] || cnt_dec_c[i] == '0;
			reload_c[i]    = exp_next_c[8*i +: COUNT_BITS];
		end
	end

	assign each_done_c  = &(seen_next_c | ~in_use_c);
	assign count_done_c = &zero_ok_c;

	always_comb begin
		case (mode_q)
			rqd_pkg::MODE_ANY:   fire_c = 1'b1;
			rqd_pkg::MODE_EACH:  fire_c = each_done_c;
			rqd_pkg::MODE_COUNT: fire_c = count_done_c;
			default:             fire_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rqd_pkg::MODE_EACH;
			num_q  <= rqd_pkg::NUM_SRC_RST;
			exp_q  <= rqd_pkg::EXPECTED_RST;
			seen_q <= '0;
			for (int i = 0; i < MAX_SOURCES; i++) begin
				cnt_q[i] <= rqd_pkg::EXPECTED_RST[8*i +: COUNT_BITS];
			end
		end else if (cfg_acc) begin
			unique case (cfg.addr)
				rqd_pkg::REG_MODE:     mode_q <= rqd_pkg::mode_t'(cfg.data[1:0]);
				rqd_pkg::REG_NUM_SRC:  num_q  <= cfg.data[rqd_pkg::NUM_W-1:0];
				rqd_pkg::REG_EXPECTED: exp_q  <= cfg.data;
				default: ;
			endcase
			if (cfg.addr == rqd_pkg::REG_MODE || cfg.addr == rqd_pkg::REG_NUM_SRC ||
			    cfg.addr == rqd_pkg::REG_EXPECTED) begin
				cnt_q <= reload_c;
			end
		end else if (req_acc && !bad_c) begin
			case (mode_q)
				rqd_pkg::MODE_EACH: begin
					seen_q <= each_done_c ? '0 : seen_next_c;
				end
				rqd_pkg::MODE_COUNT: begin
					cnt_q <= count_done_c ? reload_c : cnt_dec_c;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_acc) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			fired_q <= fire_c && !bad_c;
			bad_q   <= bad_c;
		end
	end

	`RQD_ASSERT(a_bad_never_fires, rsp_valid_q |-> !(fired_q && bad_q), "bad source fired")
	`RQD_ASSERT(a_acc_gives_beat, req_acc |=> rsp_valid_q, "accepted reply has no result")
	`RQD_ASSERT(a_each_clears, (req_acc && !bad_c && mode_q == rqd_pkg::MODE_EACH && each_done_c) |=> seen_q == '0, "seen bits not cleared on fire")
	`RQD_ASSERT(a_cfg_reloads, cfg_acc && cfg.addr == rqd_pkg::REG_MODE |=> cnt_q == reload_c, "counts not reloaded on write")
	`RQD_ASSERT_ALWAYS(a_rst_empties, !arst_n |=> !rsp_valid_q, "output valid across reset")

endmodule

@@ dv/reply_quorum_detector_tb.sv @@
module reply_quorum_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SRC_LIMIT      = rqd_pkg::MAX_SOURCES_DEF;
	localparam int RANDOM_REPLIES = 650;
	localparam int IDLE_LIMIT     = 5000;
	localparam int SETTLE_CYCLES  = 2;
	localparam int DRAIN_CYCLES   = 4;

	localparam logic [1:0]                     MODE_UNUSED = 2'd3;
	localparam logic [rqd_pkg::CFG_ADDR_W-1:0] REG_SPARE   = 4'd3;
	localparam logic [rqd_pkg::CFG_ADDR_W-1:0] REG_LAST    = 4'd15;

	typedef struct packed {
		logic fired;
		logic bad_source;
	} reply_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	rqd_req_if req_ch();
	rqd_rsp_if rsp_ch();
	rqd_cfg_if cfg_ch();

	reply_quorum_detector dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// quorum state as the block should hold it
	logic [1:0]                cur_mode;
	logic [rqd_pkg::NUM_W-1:0] cur_num;
	logic [rqd_pkg::EXP_W-1:0] cur_expected;
	logic [7:0]                seen_bits;
	logic [7:0]                left_counts [SRC_LIMIT];

	logic [rqd_pkg::SRC_W-1:0] source_q [$];
	reply_result_t             outcome_q [$];
	int                        replies_out = 0;
	int                        mismatches  = 0;
	int                        idle_cycles = 0;
	logic                      req_beat    = 1'b0;
	int                        req_gap     = 0;
	int                        req_calm    = 0;
	int                        stall_left  = 0;
	int                        stall_calm  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void reload_counts();
		for (int i = 0; i < SRC_LIMIT; i++)
			left_counts[i] = cur_expected[8*i +: 8];
	endfunction

	function automatic void apply_write(input logic [rqd_pkg::CFG_ADDR_W-1:0] idx,
			input logic [rqd_pkg::CFG_DATA_W-1:0] val);
		case (idx)
		rqd_pkg::REG_MODE:     cur_mode = val[1:0];
		rqd_pkg::REG_NUM_SRC:  cur_num = val[rqd_pkg::NUM_W-1:0];
		rqd_pkg::REG_EXPECTED: cur_expected = val;
		default:               return;
		endcase
		reload_counts();
	endfunction

	function automatic reply_result_t quorum_step(input logic [rqd_pkg::SRC_W-1:0] src);
		int            n;
		logic [7:0]    use_mask;
		reply_result_t r;
		bit            all_zero;
		n = (cur_num > SRC_LIMIT) ? SRC_LIMIT : int'(cur_num);
		use_mask = 8'((1 << n) - 1);
		r = '0;
		if (src >= n) begin
			r.bad_source = 1'b1;
			return r;
		end
		case (cur_mode)
		rqd_pkg::MODE_ANY: r.fired = 1'b1;
		rqd_pkg::MODE_EACH: begin
			seen_bits[src] = 1'b1;
			if ((seen_bits & use_mask) == use_mask) begin
				seen_bits = '0;
				r.fired = 1'b1;
			end
		end
		rqd_pkg::MODE_COUNT: begin
			if (left_counts[src] != 0)
				left_counts[src] = left_counts[src] - 8'd1;
			all_zero = 1'b1;
			for (int i = 0; i < n; i++)
				if (left_counts[i] != 0)
					all_zero = 1'b0;
			if (all_zero) begin
				reload_counts();
				r.fired = 1'b1;
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [rqd_pkg::SRC_W-1:0] pick_source(input int n);
		if (n == 0 || $urandom_range(0, 99) < 12)
			return rqd_pkg::SRC_W'($urandom_range(0, 15));
		return rqd_pkg::SRC_W'($urandom_range(0, n - 1));
	endfunction

	function automatic logic [rqd_pkg::EXP_W-1:0] pick_expected();
		logic [rqd_pkg::EXP_W-1:0] e;
		int                        r;
		for (int i = 0; i < SRC_LIMIT; i++) begin
			r = $urandom_range(0, 99);
			e[8*i +: 8] = (r < 85) ? 8'($urandom_range(0, 3)) : 8'($urandom);
		end
		return e;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// caller stands at a falling edge
	task automatic send_reply(input logic [rqd_pkg::SRC_W-1:0] src);
		source_q.push_back(src);
		replies_out++;
	endtask

	task automatic wait_idle();
		while (replies_out != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [rqd_pkg::CFG_ADDR_W-1:0] idx,
			input logic [rqd_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(negedge clk) begin : reply_driver
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_beat) begin
			if (req_gap > 0) begin
				req_ch.valid <= 1'b0;
				req_gap--;
			end else if (source_q.size() != 0) begin
				req_ch.valid  <= 1'b1;
				req_ch.source <= source_q.pop_front();
				if (req_calm > 0) begin
					req_calm--;
					req_gap = 0;
				end else begin
					req_gap = pick_gap();
					if ($urandom_range(0, 39) == 0)
						req_calm = $urandom_range(20, 60);
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : result_sink
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (stall_calm > 0) begin
				stall_calm--;
			end else begin
				stall_left = pick_gap();
				if ($urandom_range(0, 39) == 0)
					stall_calm = $urandom_range(20, 60);
			end
		end
	end

	always @(posedge clk) begin : monitor
		reply_result_t want;
		req_beat <= req_ch.valid && req_ch.ready;
		if (cfg_ch.valid && cfg_ch.ready)
			apply_write(cfg_ch.addr, cfg_ch.data);
		if (req_ch.valid && req_ch.ready)
			outcome_q.push_back(quorum_step(req_ch.source));
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (outcome_q.size() == 0) begin
				report_mismatch($sformatf("result beat with none pending (fired %b bad %b)",
					rsp_ch.fired, rsp_ch.bad_source));
			end else begin
				want = outcome_q.pop_front();
				replies_out--;
				if (rsp_ch.fired !== want.fired)
					report_mismatch($sformatf("fired %b, want %b",
						rsp_ch.fired, want.fired));
				if (rsp_ch.bad_source !== want.bad_source)
					report_mismatch($sformatf("bad_source %b, want %b",
						rsp_ch.bad_source, want.bad_source));
			end
		end
		if ((cfg_ch.valid && cfg_ch.ready) || (req_ch.valid && req_ch.ready)
				|| (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("ERROR %0t: no beat for %0d cycles", $realtime, IDLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int                        sent;
		int                        count;
		int                        pause_at;
		int                        first;
		int                        n_eff;
		logic [1:0]                m;
		logic [rqd_pkg::NUM_W-1:0] n;
		logic [rqd_pkg::EXP_W-1:0] e;

		req_ch.valid  = 1'b0;
		req_ch.source = '0;
		rsp_ch.ready  = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.addr   = '0;
		cfg_ch.data   = '0;
		cur_mode      = rqd_pkg::MODE_EACH;
		cur_num       = rqd_pkg::NUM_SRC_RST;
		cur_expected  = rqd_pkg::EXPECTED_RST;
		seen_bits     = '0;
		reload_counts();

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting: each source once over all eight, then out of range
		for (int s = 0; s < SRC_LIMIT; s++)
			send_reply(rqd_pkg::SRC_W'(s));
		send_reply(4'd8);
		send_reply(4'd15);
		wait_idle();

		// oversized source count acts as eight, largest counts
		write_reg(rqd_pkg::REG_EXPECTED, '1);
		write_reg(rqd_pkg::REG_NUM_SRC, 64'd15);
		write_reg(rqd_pkg::REG_MODE, 64'(rqd_pkg::MODE_COUNT));
		send_reply(4'd3);
		send_reply(4'd14);
		wait_idle();

		// zero counts: every good reply fires
		write_reg(rqd_pkg::REG_EXPECTED, '0);
		send_reply(4'd0);
		send_reply(4'd7);
		wait_idle();

		// counts saturate at zero
		write_reg(rqd_pkg::REG_NUM_SRC, 64'd2);
		write_reg(rqd_pkg::REG_EXPECTED, 64'h0000_0000_0000_0201);
		send_reply(4'd0);
		send_reply(4'd0);
		send_reply(4'd1);
		send_reply(4'd1);
		wait_idle();

		write_reg(rqd_pkg::REG_MODE, 64'(rqd_pkg::MODE_ANY));
		send_reply(4'd1);
		send_reply(4'd2);
		wait_idle();

		// seen bits survive a mode change
		write_reg(rqd_pkg::REG_NUM_SRC, 64'd3);
		write_reg(rqd_pkg::REG_MODE, 64'(rqd_pkg::MODE_EACH));
		send_reply(4'd0);
		send_reply(4'd1);
		wait_idle();
		write_reg(rqd_pkg::REG_MODE, 64'(rqd_pkg::MODE_ANY));
		send_reply(4'd2);
		wait_idle();
		write_reg(rqd_pkg::REG_MODE, 64'(rqd_pkg::MODE_EACH));
		send_reply(4'd2);
		wait_idle();

		write_reg(rqd_pkg::REG_MODE, 64'(MODE_UNUSED));
		send_reply(4'd0);
		send_reply(4'd5);
		wait_idle();

		// no sources; writes to unmapped indexes change nothing
		write_reg(rqd_pkg::REG_NUM_SRC, 64'd0);
		write_reg(REG_SPARE, '1);
		write_reg(REG_LAST, '0);
		send_reply(4'd0);
		wait_idle();

		sent = 0;
		while (sent < RANDOM_REPLIES) begin
			wait_idle();
			count = $urandom_range(0, 99);
			m = (count < 20) ? rqd_pkg::MODE_ANY : (count < 55) ? rqd_pkg::MODE_EACH :
				(count < 95) ? rqd_pkg::MODE_COUNT : MODE_UNUSED;
			count = $urandom_range(0, 99);
			n = (count < 8) ? 4'd0 :
				(count < 20) ? rqd_pkg::NUM_W'($urandom_range(9, 15)) :
				rqd_pkg::NUM_W'($urandom_range(1, 8));
			e = pick_expected();
			first = $urandom_range(0, 2);
			for (int j = 0; j < 3; j++) begin
				case ((first + j) % 3)
				0:       write_reg(rqd_pkg::REG_MODE, 64'(m));
				1:       write_reg(rqd_pkg::REG_NUM_SRC, 64'(n));
				default: write_reg(rqd_pkg::REG_EXPECTED, e);
				endcase
			end
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_SPARE, {$urandom, $urandom});
			n_eff = (n > SRC_LIMIT) ? SRC_LIMIT : int'(n);
			count = $urandom_range(30, 70);
			if (count > RANDOM_REPLIES - sent)
				count = RANDOM_REPLIES - sent;
			pause_at = ($urandom_range(0, 3) == 0) ? count / 2 : -1;
			for (int k = 0; k < count; k++) begin
				if (k == pause_at)
					wait_idle();
				send_reply(pick_source(n_eff));
				sent++;
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outcome_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
